[design/sgf_pkg.sv]
// ----------------------------------------------------------------------------
// Scanline gradient fader package
// Shared types, sizes and codes for the gradient fader block.
// ----------------------------------------------------------------------------
package sgf_pkg;

    localparam int LINE_COUNT    = 160;
    localparam int KEY_COUNT     = 11;
    localparam int SEG_COUNT     = KEY_COUNT - 1;
    localparam int NUM_TABLES    = 4;
    localparam int KEY_ENTRIES   = NUM_TABLES * KEY_COUNT;
    localparam int NUM_CH        = 3;
    localparam int SEGMENT_LINES = 16;
    localparam int SEG_SHIFT     = $clog2(SEGMENT_LINES);

    localparam int LINE_W     = $clog2(LINE_COUNT + 1);
    localparam int KEY_IDX_W  = $clog2(KEY_COUNT);
    localparam int KEY_ADDR_W = $clog2(KEY_ENTRIES);
    localparam int SEG_W      = (SEG_COUNT > 1) ? $clog2(SEG_COUNT) : 1;
    localparam int CH_W       = 2;
    localparam int FADE_W     = 9;
    localparam int ACC_W      = 16;
    localparam int DELTA_W    = 13;

    localparam logic [31:0] FADE_HOLD_LAST = 32'h0000_04AF;
    localparam logic [31:0] FADE_RAMP_LAST = 32'h0000_08AF;
    localparam logic [31:0] FADE_RAMP_BASE = 32'h0000_04B0;
    localparam logic [FADE_W-1:0] FADE_FULL = 9'h100;

    typedef enum logic [1:0] {
        REQ_KEY_WRITE   = 2'd0,
        REQ_FRAME_START = 2'd1,
        REQ_LINE_TICK   = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_DIFF
    } state_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] key_table;
        logic [3:0] key_slot;
        logic [7:0] key_red;
        logic [7:0] key_green;
        logic [7:0] key_blue;
    } in_t;

    typedef struct packed {
        logic [14:0] line_colour;
        logic [7:0]  line_number;
        logic        last_line;
    } out_t;

    typedef struct packed {
        logic                 key_write;
        logic                 fade_load;
        logic                 line_step;
        logic                 key_read;
        logic                 blend_mul;
        logic                 blend_diff;
        logic [KEY_IDX_W-1:0] key_idx;
        logic [CH_W-1:0]      ch;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic line_pending;
    } status_t;

endpackage

[design/sgf_ctrl.sv]
// ----------------------------------------------------------------------------
// Scanline gradient fader controller
// Decodes accepted words and sequences the per-key blend of a frame start.
// ----------------------------------------------------------------------------
module sgf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       req_type,
    input  sgf_pkg::status_t status,
    output sgf_pkg::cmd_t    cmd
);

    sgf_pkg::state_t                 state_reg, state_next;
    logic [sgf_pkg::KEY_IDX_W-1:0]   key_idx_reg, key_idx_next;
    logic [sgf_pkg::CH_W-1:0]        ch_reg, ch_next;
    logic                            accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sgf_pkg::ST_IDLE;
            key_idx_reg <= '0;
            ch_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            key_idx_reg <= key_idx_next;
            ch_reg      <= ch_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        key_idx_next = key_idx_reg;
        ch_next      = ch_reg;
        s_ready      = 1'b0;
        accept       = 1'b0;
        cmd          = '0;
        cmd.key_idx  = key_idx_reg;
        cmd.ch       = ch_reg;
        case (state_reg)
            sgf_pkg::ST_IDLE: begin
                s_ready = status.out_free;
                accept  = s_valid && status.out_free;
                if (accept) begin
                    if (req_type == sgf_pkg::REQ_KEY_WRITE) begin
                        cmd.key_write = 1'b1;
                    end else if (req_type == sgf_pkg::REQ_FRAME_START) begin
                        cmd.fade_load = 1'b1;
                        key_idx_next  = '0;
                        ch_next       = '0;
                        state_next    = sgf_pkg::ST_READ;
                    end else if (req_type == sgf_pkg::REQ_LINE_TICK) begin
                        cmd.line_step = status.line_pending;
                    end
                end
            end
            sgf_pkg::ST_READ: begin
                cmd.key_read = 1'b1;
                ch_next      = '0;
                state_next   = sgf_pkg::ST_MUL;
            end
            sgf_pkg::ST_MUL: begin
                cmd.blend_mul = 1'b1;
                state_next    = sgf_pkg::ST_DIFF;
            end
            sgf_pkg::ST_DIFF: begin
                cmd.blend_diff = 1'b1;
                if (ch_reg == sgf_pkg::CH_W'(sgf_pkg::NUM_CH - 1)) begin
                    if (key_idx_reg == sgf_pkg::KEY_IDX_W'(sgf_pkg::KEY_COUNT - 1)) begin
                        state_next = sgf_pkg::ST_IDLE;
                    end else begin
                        key_idx_next = key_idx_reg + 1'b1;
                        state_next   = sgf_pkg::ST_READ;
                    end
                end else begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = sgf_pkg::ST_MUL;
                end
            end
            default: begin
                state_next = sgf_pkg::ST_IDLE;
            end
        endcase
    end

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == sgf_pkg::ST_IDLE)
        else $error("ready raised outside idle");

    a_key_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        key_idx_reg <= sgf_pkg::KEY_IDX_W'(sgf_pkg::KEY_COUNT - 1))
        else $error("key index beyond key table");

    a_frame_start_walks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fade_load |=> state_reg == sgf_pkg::ST_READ && key_idx_reg == '0)
        else $error("frame start did not begin the key walk");

endmodule

[design/sgf_dpath.sv]
// ----------------------------------------------------------------------------
// Scanline gradient fader datapath
// Key store, fade blend with a shared multiplier, deltas, accumulators and
// the output register.
// ----------------------------------------------------------------------------
module sgf_dpath (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  sgf_pkg::in_t     in_data,
    input  sgf_pkg::cmd_t    cmd,
    output sgf_pkg::status_t status,
    output logic             m_valid,
    input  logic             m_ready,
    output sgf_pkg::out_t    m_data
);

    logic [23:0] key_mem [sgf_pkg::KEY_ENTRIES];
    logic [23:0] start_rd_reg, end_rd_reg;

    logic signed [sgf_pkg::DELTA_W-1:0] delta_reg [sgf_pkg::SEG_COUNT][sgf_pkg::NUM_CH];
    logic [sgf_pkg::ACC_W-1:0]          acc_reg  [sgf_pkg::NUM_CH];
    logic [sgf_pkg::ACC_W-1:0]          prev_reg [sgf_pkg::NUM_CH];
    logic [sgf_pkg::ACC_W-1:0]          blend_reg;

    logic                         alt_sky_reg;
    logic [31:0]                  frame_count_reg;
    logic [sgf_pkg::FADE_W-1:0]   fade_reg;
    logic [sgf_pkg::LINE_W-1:0]   line_counter_reg;
    logic                         out_valid_reg;
    sgf_pkg::out_t                out_reg;

    logic [sgf_pkg::KEY_ADDR_W-1:0] wr_addr, start_addr, end_addr;
    logic [1:0]                     start_tab;
    logic [7:0]                     chan_a, chan_b;
    logic signed [9:0]              fade_s;
    logic signed [8:0]              chan_diff;
    logic signed [18:0]             blend_sum;
    logic signed [16:0]             key_diff;
    logic signed [16:0]             key_diff_adj;
    logic [sgf_pkg::FADE_W-1:0]     fade_calc;
    logic [31:0]                    fade_ofs;
    logic [sgf_pkg::LINE_W-1:0]     seg_raw;
    logic [sgf_pkg::SEG_W-1:0]      seg;
    logic [sgf_pkg::SEG_W-1:0]      delta_wr_idx;
    logic                           slot_ok;

    assign slot_ok    = {1'b0, in_data.key_slot} < 5'(sgf_pkg::KEY_COUNT);
    assign wr_addr    = sgf_pkg::KEY_ADDR_W'(in_data.key_table * sgf_pkg::KEY_COUNT
                                             + in_data.key_slot);
    assign start_tab  = alt_sky_reg ? 2'd2 : 2'd0;
    assign start_addr = sgf_pkg::KEY_ADDR_W'(start_tab * sgf_pkg::KEY_COUNT + cmd.key_idx);
    assign end_addr   = sgf_pkg::KEY_ADDR_W'((start_tab + 2'd1) * sgf_pkg::KEY_COUNT
                                             + cmd.key_idx);

    always_ff @(posedge aclk) begin
        if (cmd.key_write && slot_ok) begin
            key_mem[wr_addr] <= {in_data.key_red, in_data.key_green, in_data.key_blue};
        end
        if (cmd.key_read) begin
            start_rd_reg <= key_mem[start_addr];
            end_rd_reg   <= key_mem[end_addr];
        end
    end

    always_comb begin
        case (cmd.ch)
            2'd0: begin
                chan_a = start_rd_reg[23:16];
                chan_b = end_rd_reg[23:16];
            end
            2'd1: begin
                chan_a = start_rd_reg[15:8];
                chan_b = end_rd_reg[15:8];
            end
            default: begin
                chan_a = start_rd_reg[7:0];
                chan_b = end_rd_reg[7:0];
            end
        endcase
    end

    assign fade_s    = $signed({1'b0, fade_reg});
    assign chan_diff = $signed({1'b0, chan_b}) - $signed({1'b0, chan_a});
    assign blend_sum = fade_s * chan_diff + $signed({3'b000, chan_a, 8'h00});

    assign key_diff     = $signed({1'b0, blend_reg}) - $signed({1'b0, prev_reg[cmd.ch]});
    assign key_diff_adj = key_diff[16] ? key_diff + 17'sd15 : key_diff;
    assign delta_wr_idx = sgf_pkg::SEG_W'(cmd.key_idx - 1'b1);

    assign fade_ofs  = (frame_count_reg - sgf_pkg::FADE_RAMP_BASE) >> 2;
    assign fade_calc = (frame_count_reg <= sgf_pkg::FADE_HOLD_LAST) ? '0 :
                       (frame_count_reg <= sgf_pkg::FADE_RAMP_LAST) ?
                       sgf_pkg::FADE_W'(fade_ofs) : sgf_pkg::FADE_FULL;

    always_comb begin
        seg_raw = line_counter_reg >> sgf_pkg::SEG_SHIFT;
        if (seg_raw > sgf_pkg::LINE_W'(sgf_pkg::SEG_COUNT - 1)) begin
            seg = sgf_pkg::SEG_W'(sgf_pkg::SEG_COUNT - 1);
        end else begin
            seg = sgf_pkg::SEG_W'(seg_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.blend_mul) begin
            blend_reg <= blend_sum[15:0];
        end
        if (cmd.blend_diff) begin
            prev_reg[cmd.ch] <= blend_reg;
            if (cmd.key_idx == '0) begin
                acc_reg[cmd.ch] <= blend_reg;
            end else begin
                delta_reg[delta_wr_idx][cmd.ch] <= sgf_pkg::DELTA_W'(key_diff_adj >>> 4);
            end
        end
        if (cmd.line_step) begin
            for (int c = 0; c < sgf_pkg::NUM_CH; c++) begin
                acc_reg[c] <= acc_reg[c] + sgf_pkg::ACC_W'(delta_reg[seg][c]);
            end
            out_reg.line_colour <= {acc_reg[2][15:11], acc_reg[1][15:11], acc_reg[0][15:11]};
            out_reg.line_number <= 8'(line_counter_reg);
            out_reg.last_line   <= line_counter_reg == sgf_pkg::LINE_W'(sgf_pkg::LINE_COUNT - 1);
        end
        if (cmd.fade_load) begin
            fade_reg <= fade_calc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alt_sky_reg      <= 1'b0;
            frame_count_reg  <= '0;
            line_counter_reg <= sgf_pkg::LINE_W'(sgf_pkg::LINE_COUNT);
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                alt_sky_reg <= cfg_wr_data;
            end
            if (cmd.fade_load) begin
                frame_count_reg  <= frame_count_reg + 32'd1;
                line_counter_reg <= '0;
            end else if (cmd.line_step) begin
                line_counter_reg <= line_counter_reg + 1'b1;
            end
            if (cmd.line_step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free     = !out_valid_reg || m_ready;
    assign status.line_pending = line_counter_reg < sgf_pkg::LINE_W'(sgf_pkg::LINE_COUNT);
    assign m_valid             = out_valid_reg;
    assign m_data              = out_reg;

    a_line_counter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        line_counter_reg <= sgf_pkg::LINE_W'(sgf_pkg::LINE_COUNT))
        else $error("line counter beyond frame");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.line_step |-> !out_valid_reg || m_ready)
        else $error("line step would overwrite a pending word");

    a_step_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.line_step |=> out_valid_reg && out_reg.line_number == 8'($past(line_counter_reg)))
        else $error("line step did not present its word");

endmodule

[design/scanline_gradient_fader.sv]
// ----------------------------------------------------------------------------
// Scanline gradient fader
// Blends a start/end pair of its four key colour tables by a frame-timed fade
// and emits one BGR555 colour word per scanline.
// ----------------------------------------------------------------------------
//   Channel   Ports                         Word
//   input     s_valid s_ready s_data        sgf_pkg::in_t
//   result    m_valid m_ready m_data        sgf_pkg::out_t
//   config    cfg_wr_en cfg_wr_data         alternate sky select
//
// Key writes and line ticks are carried out as they are accepted.
// A frame start is accepted, then walks each key (one key store read, then a
// multiply and a difference step for each of three channels) through the
// single shared blend multiplier.
// Every input word is held off while the previous colour word waits to be
// taken, and for the whole key walk of a frame start.
// Reset is synchronous; the key store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module scanline_gradient_fader (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  sgf_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output sgf_pkg::out_t m_data
);

    sgf_pkg::cmd_t    cmd;
    sgf_pkg::status_t status;

    sgf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .req_type (s_data.req_type),
        .status   (status),
        .cmd      (cmd)
    );

    sgf_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_data),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
